/* rtl/sibp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sibp_pkg: shared types and constants of the set bit index pager
// Widths of the stream payloads, register codes and the command/status
// structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package sibp_pkg;

	localparam int WORD_W     = 64;
	localparam int POS_W      = 6;
	localparam int WCNT_W     = 25;
	localparam int INDEX_W    = 31;
	localparam int NEXT_W     = 32;
	localparam int COUNT_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;
	localparam int OUT_DATA_W = 80;
	localparam int OUT_USER_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_START_INDEX  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESULT_LIMIT = 2'd1;

	localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};
	localparam logic [NEXT_W-1:0]  NEXT_EXHAUSTED = {NEXT_W{1'b1}};

	typedef struct packed {
		logic load;
		logic emit;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic has_result;
		logic out_free;
	} status_t;

endpackage : sibp_pkg
`default_nettype wire

/* rtl/sibp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sibp_ctrl: sequencing of one input word
// Takes a word, lets the datapath emit its results one per free output slot,
// then commits the per-word state update and returns for the next word.
// ----------------------------------------------------------------------------
module sibp_ctrl
	import sibp_pkg::*;
(
	input  wire     clk,
	input  wire     arst_n,
	input  wire     s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WORK = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_WORK;
				end
			end
			ST_WORK: begin
				if (!status.has_result) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule : sibp_ctrl
`default_nettype wire

/* rtl/sibp_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sibp_dp: datapath of the set bit index pager
// Configuration registers, page state, the pending bit word with its
// find-first-set unit, and the output register of the result stream.
// ----------------------------------------------------------------------------
module sibp_dp
	import sibp_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	input  cmd_t                   cmd,
	output status_t                status,
	input  wire [WORD_W-1:0]       word_bits,
	input  wire                    last_word,
	input  wire                    cfg_we,
	input  wire [CFG_IDX_W-1:0]    cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_data,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [INDEX_W-1:0]     match_index,
	output logic                   has_match,
	output logic                   end_of_run,
	output logic                   page_done,
	output logic [NEXT_W-1:0]      next_start,
	output logic [COUNT_W-1:0]     found_count
);

	// Configuration
	logic [INDEX_W-1:0] start_q;
	logic [COUNT_W-1:0] limit_q;

	// Page state
	logic [WCNT_W-1:0]  wcnt_q;
	logic [COUNT_W-1:0] rep_q;
	logic               fin_q;

	// Per-word working state
	logic [WORD_W-1:0]  pend_q;
	logic               last_q;
	logic               skip_q;
	logic               done_q;
	logic               single_q;
	logic [NEXT_W-1:0]  snext_q;
	logic [COUNT_W-1:0] scount_q;

	// Output register
	logic               ov_q;
	logic [INDEX_W-1:0] o_idx_q;
	logic               o_match_q;
	logic               o_end_q;
	logic               o_done_q;
	logic [NEXT_W-1:0]  o_next_q;
	logic [COUNT_W-1:0] o_count_q;

	logic [WCNT_W-1:0]  start_word;
	logic [POS_W-1:0]   start_off;
	logic               before_start;
	logic [WORD_W-1:0]  masked;
	logic [INDEX_W-1:0] base;

	logic [WORD_W-1:0]  lowbit;
	logic [WORD_W-1:0]  rest;
	logic [POS_W-1:0]   pos;
	logic [INDEX_W-1:0] idx;
	logic [COUNT_W-1:0] cnt;
	logic               hit;
	logic               exhausted;
	logic [NEXT_W-1:0]  hit_next;

	assign start_word   = start_q[INDEX_W-1:POS_W];
	assign start_off    = start_q[POS_W-1:0];
	assign before_start = (wcnt_q < start_word);
	assign base         = {wcnt_q, {POS_W{1'b0}}};
	assign masked       = (wcnt_q == start_word) ?
		(word_bits & ({WORD_W{1'b1}} << start_off)) : word_bits;

	// The lowest set bit is isolated with one add, then encoded by OR trees.
	assign lowbit = pend_q & (~pend_q + {{(WORD_W-1){1'b0}}, 1'b1});
	assign rest   = pend_q & ~lowbit;

	always_comb begin
		pos = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (lowbit[i]) begin
				pos = pos | POS_W'(i);
			end
		end
	end

	assign idx       = base | {{(INDEX_W-POS_W){1'b0}}, pos};
	assign cnt       = rep_q + {{(COUNT_W-1){1'b0}}, 1'b1};
	assign hit       = (cnt == limit_q);
	assign exhausted = !hit && (rest == '0) && last_q;
	assign hit_next  = (idx == INDEX_MAX) ? NEXT_EXHAUSTED :
		{1'b0, idx + {{(INDEX_W-1){1'b0}}, 1'b1}};

	assign status.has_result = single_q || (pend_q != '0);
	assign status.out_free   = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			limit_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_INDEX:  start_q <= cfg_data;
				REG_RESULT_LIMIT: limit_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q   <= '0;
			rep_q    <= '0;
			fin_q    <= 1'b0;
			pend_q   <= '0;
			last_q   <= 1'b0;
			skip_q   <= 1'b0;
			done_q   <= 1'b0;
			single_q <= 1'b0;
			snext_q  <= '0;
			scount_q <= '0;
		end else begin
			if (cmd.load) begin
				last_q   <= last_word;
				skip_q   <= fin_q;
				done_q   <= 1'b0;
				snext_q  <= NEXT_EXHAUSTED;
				scount_q <= rep_q;
				pend_q   <= '0;
				single_q <= 1'b0;
				if (fin_q) begin
					single_q <= 1'b0;
				end else if (before_start) begin
					// Vector ends before the start word is reached.
					single_q <= last_word;
				end else if (limit_q == '0) begin
					single_q <= 1'b1;
					snext_q  <= {1'b0, start_q};
					scount_q <= '0;
				end else if (rep_q >= limit_q) begin
					single_q <= 1'b1;
					snext_q  <= {1'b0, base};
				end else begin
					pend_q   <= masked;
					single_q <= (masked == '0) && last_word;
				end
			end
			if (cmd.emit) begin
				if (single_q) begin
					single_q <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					rep_q  <= cnt;
					pend_q <= hit ? '0 : rest;
					if (hit || exhausted) begin
						done_q <= 1'b1;
					end
				end
			end
			if (cmd.finish) begin
				if (last_q) begin
					wcnt_q <= '0;
					rep_q  <= '0;
					fin_q  <= 1'b0;
				end else if (!skip_q) begin
					fin_q  <= done_q;
					wcnt_q <= wcnt_q + {{(WCNT_W-1){1'b0}}, 1'b1};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (single_q) begin
				o_idx_q   <= '0;
				o_match_q <= 1'b0;
				o_end_q   <= 1'b1;
				o_done_q  <= 1'b1;
				o_next_q  <= snext_q;
				o_count_q <= scount_q;
			end else begin
				o_idx_q   <= idx;
				o_match_q <= 1'b1;
				o_end_q   <= hit || (rest == '0);
				o_done_q  <= hit || exhausted;
				o_next_q  <= hit ? hit_next : (exhausted ? NEXT_EXHAUSTED : '0);
				o_count_q <= (hit || exhausted) ? cnt : '0;
			end
		end
	end

	assign out_valid   = ov_q;
	assign match_index = o_idx_q;
	assign has_match   = o_match_q;
	assign end_of_run  = o_end_q;
	assign page_done   = o_done_q;
	assign next_start  = o_next_q;
	assign found_count = o_count_q;

endmodule : sibp_dp
`default_nettype wire

/* rtl/set_bit_index_pager.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// set_bit_index_pager: pages through the set bits of a streamed bit vector
// A word is taken in the idle state and then produces its results (up to
// 64, one index per cycle while the output register is free, from a single
// find-first-set unit that walks the word's pending bits) before its
// per-word state update is committed. The next word is taken while the
// last result still waits in the output register. Configuration writes are
// always accepted and are to be issued only while no word is in flight.
// ----------------------------------------------------------------------------
module set_bit_index_pager
	import sibp_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire [WORD_W-1:0]      s_tdata,   // [63:0] word_bits
	input  wire                   s_tlast,   // last_word
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [30:0] match_index, [62:31] next_start,
	                                         // [78:63] found_count, [79] zero
	output logic [OUT_USER_W-1:0] m_tuser,   // [0] has_match, [1] page_done
	output logic                  m_tlast,   // end_of_run
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data
);

	cmd_t               cmd;
	status_t            status;
	logic [INDEX_W-1:0] match_index;
	logic               has_match;
	logic               page_done;
	logic [NEXT_W-1:0]  next_start;
	logic [COUNT_W-1:0] found_count;

	assign cfg_ready = 1'b1;

	sibp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sibp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.word_bits   (s_tdata),
		.last_word   (s_tlast),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.match_index (match_index),
		.has_match   (has_match),
		.end_of_run  (m_tlast),
		.page_done   (page_done),
		.next_start  (next_start),
		.found_count (found_count)
	);

	assign m_tdata = {1'b0, found_count, next_start, match_index};
	assign m_tuser = {page_done, has_match};

endmodule : set_bit_index_pager
`default_nettype wire

/* rtl/sibp_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sibp_checker: port-level checks of the set bit index pager
// Watches the result stream, checks that a stalled result holds, and checks field rules that tie its groups.
// ----------------------------------------------------------------------------
module sibp_checker
	import sibp_pkg::*;
(
	input wire                  clk,
	input wire                  arst_n,
	input wire                  m_tvalid,
	input wire                  m_tready,
	input wire [OUT_DATA_W-1:0] m_tdata,
	input wire [OUT_USER_W-1:0] m_tuser,
	input wire                  m_tlast
);

	// A stalled result transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// A result without a match carries a zero index.
	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[30:0] == 31'd0)
		else $error("index set on a result without a match");

	// Resume index and count are zero unless the page finishes.
	a_page_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata[78:31] == 48'd0)
		else $error("page fields set before the page finished");

	// The result that finishes a page is always the last of its word.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("page finished on a result that is not the last of its word");

endmodule : sibp_checker

bind set_bit_index_pager sibp_checker u_sibp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

/* sim/set_bit_index_pager_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// set_bit_index_pager_tb: self-checking bench for the set bit index pager
// Streams bit vector words into the block with random gaps and output stalls.
// A cycle-free scan of each accepted word predicts the page results. Every
// result transaction is checked field by field against the oldest
// prediction. Registers change only while the block is idle.
// ----------------------------------------------------------------------------
module set_bit_index_pager_tb;
	import sibp_pkg::*;

	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic [INDEX_W-1:0] match_index;
		logic               has_match;
		logic               end_of_run;
		logic               page_done;
		logic [NEXT_W-1:0]  next_start;
		logic [COUNT_W-1:0] found_count;
	} index_result_t;

	typedef struct {
		logic [WORD_W-1:0] bits;
		logic              last;
	} word_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [WORD_W-1:0]     s_tdata;    // [63:0] word_bits
	logic                  s_tlast;    // last_word
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;    // [30:0] match_index, [62:31] next_start,
	                                   // [78:63] found_count, [79] zero
	logic [OUT_USER_W-1:0] m_tuser;    // [0] has_match, [1] page_done
	logic                  m_tlast;    // end_of_run
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	set_bit_index_pager dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Scanner state mirrored from the block, plus its register settings.
	logic [INDEX_W-1:0] cur_start;
	logic [COUNT_W-1:0] cur_limit;
	logic [WCNT_W-1:0]  sc_word_cnt;
	logic [COUNT_W-1:0] sc_reported;
	logic               sc_finished;

	index_result_t index_results_q[$];
	word_item_t    word_q[$];
	int            send_gap;
	int            stall_left;
	int            sent_words;
	int            fail_count;
	bit            burst_mode;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [WORD_W-1:0] random_word();
		logic [WORD_W-1:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: w = '0;
			1: w = '1;
			2: w = {{(WORD_W-1){1'b0}}, 1'b1} << $urandom_range(0, WORD_W - 1);
			3: w = w & {$urandom, $urandom} & {$urandom, $urandom};
			4: w = w | {$urandom, $urandom};
			default: w = w;
		endcase
		return w;
	endfunction

	function automatic void rearm_scan();
		sc_word_cnt = '0;
		sc_reported = '0;
		sc_finished = 1'b0;
	endfunction

	function automatic index_result_t page_end(logic [NEXT_W-1:0] next,
	                                           logic [COUNT_W-1:0] count);
		index_result_t r;
		r = '0;
		r.page_done = 1'b1;
		r.next_start = next;
		r.found_count = count;
		return r;
	endfunction

	// Works out the results one accepted word causes and queues them.
	function automatic void scan_word(logic [WORD_W-1:0] word, logic last);
		logic [WCNT_W-1:0]  start_word;
		logic [POS_W-1:0]   start_off;
		logic [INDEX_W-1:0] base;
		logic [INDEX_W-1:0] idx;
		logic [WORD_W-1:0]  pend;
		index_result_t      r;
		index_result_t      run[$];
		bit                 done;
		int                 p;
		start_word = cur_start[INDEX_W-1:POS_W];
		start_off = cur_start[POS_W-1:0];
		base = {sc_word_cnt, {POS_W{1'b0}}};
		done = 1'b0;
		if (sc_finished) begin
			if (last) rearm_scan();
			return;
		end
		if (sc_word_cnt < start_word) begin
			if (last) begin
				run.push_back(page_end(NEXT_EXHAUSTED, sc_reported));
				done = 1'b1;
			end
		end else if (cur_limit == 0) begin
			run.push_back(page_end({1'b0, cur_start}, '0));
			done = 1'b1;
		end else if (sc_reported >= cur_limit) begin
			// Limit was lowered to or below what this page already reported.
			run.push_back(page_end({1'b0, base}, sc_reported));
			done = 1'b1;
		end else begin
			pend = word;
			if (sc_word_cnt == start_word) pend &= {WORD_W{1'b1}} << start_off;
			while (pend != 0 && sc_reported < cur_limit) begin
				p = 0;
				while (!pend[p]) p++;
				pend[p] = 1'b0;
				idx = {sc_word_cnt, POS_W'(p)};
				sc_reported++;
				r = '0;
				r.match_index = idx;
				r.has_match = 1'b1;
				if (sc_reported == cur_limit) begin
					r.page_done = 1'b1;
					r.next_start = (idx == INDEX_MAX) ? NEXT_EXHAUSTED :
						{1'b0, idx} + NEXT_W'(1);
					r.found_count = sc_reported;
					done = 1'b1;
				end
				run.push_back(r);
			end
			if (!done && last) begin
				if (run.size() > 0) begin
					r = run.pop_back();
					r.page_done = 1'b1;
					r.next_start = NEXT_EXHAUSTED;
					r.found_count = sc_reported;
					run.push_back(r);
				end else begin
					run.push_back(page_end(NEXT_EXHAUSTED, sc_reported));
				end
				done = 1'b1;
			end
		end
		if (run.size() > 0) begin
			r = run.pop_back();
			r.end_of_run = 1'b1;
			run.push_back(r);
		end
		foreach (run[i]) index_results_q.push_back(run[i]);
		if (last) begin
			rearm_scan();
		end else begin
			if (done) sc_finished = 1'b1;
			sc_word_cnt++;
		end
	endfunction

	function automatic void check_result();
		index_result_t got;
		index_result_t want;
		got.match_index = m_tdata[30:0];
		got.next_start = m_tdata[62:31];
		got.found_count = m_tdata[78:63];
		got.has_match = m_tuser[0];
		got.page_done = m_tuser[1];
		got.end_of_run = m_tlast;
		if (index_results_q.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected result: idx=%0d match=%0b last=%0b done=%0b next=%0d cnt=%0d",
				         got.match_index, got.has_match, got.end_of_run, got.page_done,
				         $signed(got.next_start), got.found_count);
			return;
		end
		want = index_results_q.pop_front();
		if (got.match_index != want.match_index || got.has_match != want.has_match ||
		    got.end_of_run != want.end_of_run || got.page_done != want.page_done ||
		    got.next_start != want.next_start || got.found_count != want.found_count) begin
			fail_count++;
			if (fail_count <= 10)
				$display({"result mismatch: expected idx=%0d match=%0b last=%0b done=%0b ",
				          "next=%0d cnt=%0d, got idx=%0d match=%0b last=%0b done=%0b ",
				          "next=%0d cnt=%0d"},
				         want.match_index, want.has_match, want.end_of_run, want.page_done,
				         $signed(want.next_start), want.found_count,
				         got.match_index, got.has_match, got.end_of_run, got.page_done,
				         $signed(got.next_start), got.found_count);
		end
	endfunction

	// Word driver: one transaction in flight, random gaps between words outside burst mode.
	always @(posedge clk) begin : drive_words
		word_item_t w;
		if (arst_n) begin
			if (s_tvalid && s_tready) scan_word(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (word_q.size() > 0) begin
					w = word_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= w.bits;
					s_tlast <= w.last;
					if (!burst_mode) send_gap = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure outside burst mode.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) check_result();
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!burst_mode) stall_left = pick_gap();
			end
		end
	end

	task automatic wait_drained();
		do @(negedge clk);
		while (word_q.size() > 0 || s_tvalid || index_results_q.size() > 0);
	endtask

	// Words that cause no result may still be in the block once the last
	// result is out, so allow for a full word before touching registers.
	task automatic wait_idle();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] which, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		do @(posedge clk);
		while (!cfg_ready);
		case (which)
			REG_START_INDEX:  cur_start = value[INDEX_W-1:0];
			REG_RESULT_LIMIT: cur_limit = value[COUNT_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_word(logic [WORD_W-1:0] bits, logic last);
		word_item_t w;
		w.bits = bits;
		w.last = last;
		word_q.push_back(w);
		sent_words++;
	endtask

	task automatic queue_random_words(int n, bit with_last);
		for (int i = 0; i < n; i++) queue_word(random_word(), with_last && i == n - 1);
	endtask

	function automatic logic [CFG_DATA_W-1:0] random_start();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CFG_DATA_W'(INDEX_MAX);
			2: return CFG_DATA_W'($urandom_range(512, INDEX_MAX));
			default: return CFG_DATA_W'($urandom_range(0, 8 * WORD_W - 1));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_limit();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CFG_DATA_W'(16'hFFFF);
			2: return CFG_DATA_W'(1);
			3, 4: return CFG_DATA_W'($urandom_range(2, 8));
			default: return CFG_DATA_W'($urandom_range(9, 200));
		endcase
	endfunction

	initial begin
		int n;
		int k;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		m_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_START_INDEX;
		cfg_data <= '0;
		cur_start = '0;
		cur_limit = '0;
		rearm_scan();
		send_gap = 0;
		stall_left = 0;
		sent_words = 0;
		fail_count = 0;
		burst_mode = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: zero limit at the start word hands back the start.
		queue_word('1, 1'b1);
		wait_idle();
		// Widest limit; the vector runs out with matches at both word ends.
		write_reg(REG_RESULT_LIMIT, CFG_DATA_W'(16'hFFFF));
		queue_word('1, 1'b0);
		queue_word('0, 1'b0);
		queue_word(64'h8000_0000_0000_0001, 1'b1);
		wait_idle();
		// Start offset inside word one, limit reached, later words ignored.
		write_reg(REG_START_INDEX, CFG_DATA_W'(70));
		write_reg(REG_RESULT_LIMIT, CFG_DATA_W'(3));
		queue_word('1, 1'b0);
		queue_word('1, 1'b0);
		queue_word('1, 1'b0);
		queue_word('0, 1'b1);
		wait_idle();
		// Start beyond the end of the vector.
		write_reg(REG_START_INDEX, CFG_DATA_W'(INDEX_MAX));
		queue_word('1, 1'b0);
		queue_word('1, 1'b1);
		wait_idle();
		// Only bit below the start offset is masked; vector ends empty-handed.
		write_reg(REG_START_INDEX, CFG_DATA_W'(130));
		write_reg(REG_RESULT_LIMIT, CFG_DATA_W'(10));
		queue_word('0, 1'b0);
		queue_word('0, 1'b0);
		queue_word(64'h1, 1'b0);
		queue_word('0, 1'b1);
		wait_idle();
		// Limit lowered under the count already reported in this page.
		write_reg(REG_START_INDEX, '0);
		write_reg(REG_RESULT_LIMIT, CFG_DATA_W'(40));
		queue_word(64'h3FF, 1'b0);
		wait_idle();
		write_reg(REG_RESULT_LIMIT, CFG_DATA_W'(5));
		queue_word('1, 1'b0);
		queue_word('1, 1'b1);
		wait_idle();
		// Limit of one hit on the top bit of a word.
		write_reg(REG_START_INDEX, CFG_DATA_W'(63));
		write_reg(REG_RESULT_LIMIT, CFG_DATA_W'(1));
		queue_word(64'h8000_0000_0000_0000, 1'b1);
		queue_word('0, 1'b1);
		wait_idle();

		while (sent_words < 220) begin
			burst_mode = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0) write_reg(REG_START_INDEX, random_start());
			if ($urandom_range(0, 2) == 0) write_reg(REG_RESULT_LIMIT, random_limit());
			n = $urandom_range(1, 8);
			if (n > 1 && $urandom_range(0, 4) == 0) begin
				// Pause mid-vector until every result is out, then resume,
				// sometimes with a lower limit.
				k = $urandom_range(1, n - 1);
				queue_random_words(k, 1'b0);
				if ($urandom_range(0, 1) == 0) begin
					wait_idle();
					if (sc_reported > 0 && $urandom_range(0, 1) == 0)
						write_reg(REG_RESULT_LIMIT, CFG_DATA_W'($urandom_range(1, sc_reported)));
					else
						write_reg(REG_RESULT_LIMIT, random_limit());
				end else begin
					wait_drained();
				end
				queue_random_words(n - k, 1'b1);
			end else begin
				queue_random_words(n, 1'b1);
				if ($urandom_range(0, 2) == 0) queue_random_words($urandom_range(1, 6), 1'b1);
			end
			wait_idle();
		end

		if (fail_count == 0)
			$display("set_bit_index_pager_tb OK");
		else
			$display("set_bit_index_pager_tb NOT OK");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("set_bit_index_pager_tb NOT OK");
		$finish;
	end

endmodule : set_bit_index_pager_tb
`default_nettype wire

/* sim.f */
rtl/sibp_pkg.sv
rtl/sibp_ctrl.sv
rtl/sibp_dp.sv
rtl/set_bit_index_pager.sv
rtl/sibp_checker.sv
sim/set_bit_index_pager_tb.sv
